// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl of the security element parser
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, quiet while reset is asserted
`define WRIP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked property, also active during reset
`define WRIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/wrip_pkg.sv =====
// types, codes and constants of the security element parser
// no dependencies; used by wrip_step, wrip_out_fifo and the parser top level
package wrip_pkg;

	// parse phase codes
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_LEN   = 4'd1;
	localparam logic [3:0] PH_HDR   = 4'd2;
	localparam logic [3:0] PH_VER   = 4'd3;
	localparam logic [3:0] PH_GROUP = 4'd4;
	localparam logic [3:0] PH_PCNT  = 4'd5;
	localparam logic [3:0] PH_PLIST = 4'd6;
	localparam logic [3:0] PH_ACNT  = 4'd7;
	localparam logic [3:0] PH_ALIST = 4'd8;
	localparam logic [3:0] PH_DONE  = 4'd9;

	// element kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_RSN  = 2'd1;
	localparam logic [1:0] KIND_WPA  = 2'd2;

	// element ids
	localparam logic [7:0] ID_RSN = 8'h30;
	localparam logic [7:0] ID_WPA = 8'hdd;

	// suite OUIs
	localparam logic [23:0] OUI_RSN = 24'h000fac;
	localparam logic [23:0] OUI_WPA = 24'h0050f2;

	// vendor header of a WPA element: OUI then type 1
	localparam logic [7:0] WPA_HDR [4] = '{8'h00, 8'h50, 8'hf2, 8'h01};

	// length limits
	localparam logic [11:0] MAX_ELEMENT_BYTES = 12'd257;
	localparam logic [11:0] RSN_MIN_LEN       = 12'd4;
	localparam logic [11:0] WPA_MIN_LEN       = 12'd8;
	localparam logic [11:0] POS_MAX           = 12'hfff;

	// cipher and key management codes
	localparam logic [2:0] GROUP_RESET = 3'd6;
	localparam logic [2:0] GROUP_UNDEF = 3'd6;
	localparam logic [7:0] GROUP_MAX   = 8'd5;

	localparam logic [7:0] PW_SEL_NONE = 8'd0;
	localparam logic [7:0] PW_SEL_TKIP = 8'd2;
	localparam logic [7:0] PW_SEL_CCMP = 8'd4;
	localparam logic [3:0] PW_NONE     = 4'b0001;
	localparam logic [3:0] PW_TKIP     = 4'b0010;
	localparam logic [3:0] PW_CCMP     = 4'b0100;
	localparam logic [3:0] PW_UNKNOWN  = 4'b1000;

	localparam logic [7:0] AKM_SEL_NONE = 8'd0;
	localparam logic [7:0] AKM_SEL_EAP  = 8'd1;
	localparam logic [7:0] AKM_SEL_PSK  = 8'd2;
	localparam logic [5:0] KM_UNDEF      = 6'b000000;
	localparam logic [5:0] KM_NONE       = 6'b000001;
	localparam logic [5:0] KM_ADHOC_NONE = 6'b000010;
	localparam logic [5:0] KM_EAP        = 6'b000100;
	localparam logic [5:0] KM_8021X      = 6'b001000;
	localparam logic [5:0] KM_PSK        = 6'b010000;

	localparam logic [1:0] FLAG_WPA = 2'b01;
	localparam logic [1:0] FLAG_RSN = 2'b10;

	// result buffer
	localparam int FIFO_DEPTH = 3;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  ie_byte;
		logic        first_byte;
		logic        last_byte;
		logic [11:0] available_length;
		logic        adhoc_mode;
		logic [2:0]  prior_group;
		logic [3:0]  prior_pairwise;
		logic [5:0]  prior_key_mgmt;
		logic [1:0]  prior_protocols;
	} wrip_in_t;

	typedef struct packed {
		logic [2:0] group_cipher;
		logic [3:0] pairwise_flags;
		logic [5:0] key_mgmt_flags;
		logic [1:0] protocol_flags;
	} wrip_out_t;

	typedef struct packed {
		logic [11:0] byte_position;
		logic [11:0] effective_length;
		logic [1:0]  element_kind;
		logic [3:0]  parse_phase;
		logic [15:0] suite_count;
		logic [23:0] suite_bytes;
		logic [2:0]  acc_group;
		logic [3:0]  acc_pairwise;
		logic [5:0]  acc_key_mgmt;
		logic [1:0]  acc_protocols;
		logic        adhoc_flag;
		logic        parse_stopped;
	} wrip_state_t;

	// parse state after reset: idle, group code undefined, all flags clear
	localparam wrip_state_t STATE_RESET = '{
		byte_position:    12'd0,
		effective_length: 12'd0,
		element_kind:     KIND_NONE,
		parse_phase:      PH_IDLE,
		suite_count:      16'd0,
		suite_bytes:      24'd0,
		acc_group:        GROUP_RESET,
		acc_pairwise:     4'd0,
		acc_key_mgmt:     KM_UNDEF,
		acc_protocols:    2'd0,
		adhoc_flag:       1'b0,
		parse_stopped:    1'b0
	};

	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic                  full;
	} wrip_fifo_stat_t;

endpackage

// ===== rtl/core/wrip_stream_if.sv =====
// valid/ready channel carrying one word of a given payload type
// depends on nothing; payload types come from wrip_pkg
interface wrip_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/wpa_rsn_ie_parser_core.sv =====
// top level of the 802.11 RSN / WPA security element parser
// depends on wrip_pkg, wrip_stream_if, wrip_step, wrip_out_fifo, assert_macros.svh
//
// usage
// - ie_bytes: one word per element byte, element id first (first_byte set),
//   prior cipher / key management / protocol values and available_length
//   ride with the id byte; last_byte marks the final byte delivered
// - result: one word per last_byte word, the group code and the pairwise,
//   key management and protocol flags after that byte
// - every byte lands in the input register; in the next cycle it updates
//   the parse state and, if last, enters the result buffer
// - a last byte passes the input register and is then written into the result
//   buffer, whose registered occupancy raises the result valid
// - throughput is one byte per cycle while ready is high; the parse state
//   register loops back through the per-byte next-state logic
// - ready only looks at registered occupancy: it drops when the input
//   register plus the three-entry result buffer could not hold another
//   result, so a stalled receiver backs up the byte side once the buffer fills
// - reset clears the parse state (group code undefined, all flags zero),
//   the input valid flag and the result buffer occupancy
`include "assert_macros.svh"

module wpa_rsn_ie_parser_core import wrip_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	wrip_stream_if.sink   ie_bytes,
	wrip_stream_if.source result
);

	// input register
	wrip_in_t        word_s1;
	logic            valid_s1;

	// parse state
	wrip_state_t     state_q;
	wrip_state_t     state_nxt;
	wrip_out_t       res_nxt;

	wrip_fifo_stat_t fifo_stat;
	logic            accept;
	logic            push;
	logic [FIFO_CNT_W:0] pending;

	// terms of the checks below
	logic            room_ok;
	logic            past_len;
	logic            len_ok;

	// words that may still turn into results: buffered plus in flight
	assign pending        = {1'b0, fifo_stat.count} + (FIFO_CNT_W + 1)'(valid_s1);
	assign ie_bytes.ready = (pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign accept         = ie_bytes.valid && ie_bytes.ready;
	assign push           = valid_s1 && word_s1.last_byte;

	always_ff @(posedge clk) begin
		if (accept) word_s1 <= ie_bytes.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// byte at a time parse logic
	wrip_step u_step (
		.state (state_q),
		.word  (word_s1),
		.next  (state_nxt),
		.res   (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// result buffer and output channel
	wrip_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_nxt),
		.result    (result),
		.stat      (fifo_stat)
	);

	assign room_ok  = !fifo_stat.full || (result.valid && result.ready);
	assign past_len = (state_q.parse_phase != PH_IDLE) && (state_q.parse_phase != PH_LEN);
	assign len_ok   = (state_q.effective_length <= MAX_ELEMENT_BYTES);

	// buffer never takes a result it has no room for
	`WRIP_ASSERT(a_no_overflow, clk, arst_n, push |-> room_ok, "result buffer overflow")
	// an accepted word is always worked on in the next cycle
	`WRIP_ASSERT(a_accept_s1, clk, arst_n, accept |=> valid_s1, "accepted word lost before parse")
	// once past the length byte the element length is clamped
	`WRIP_ASSERT(a_len_clamp, clk, arst_n, past_len |-> len_ok, "element length not clamped")

endmodule

// ===== rtl/core/wrip_step.sv =====
// per-byte next-state logic of the security element parser
// depends on wrip_pkg
module wrip_step import wrip_pkg::*; (
	input  wrip_state_t state,
	input  wrip_in_t    word,
	output wrip_state_t next,
	output wrip_out_t   res
);

	logic [7:0]  b;
	logic [11:0] pos;
	logic        run;
	logic [11:0] len_w;
	logic [1:0]  sub_p;
	logic [1:0]  sub_l;
	logic [23:0] oui;
	logic        oui_hit;
	logic [15:0] cnt_new;
	logic [18:0] need;
	logic [15:0] cnt_dec;

	// suite bytes are gathered MSB first
	function automatic logic [23:0] collect(logic [1:0] sub, logic [23:0] cur, logic [7:0] v);
		logic [23:0] r;
		r = cur;
		unique case (sub)
			2'd0:    r = {v, 16'h0000};
			2'd1:    r = {cur[23:16], v, 8'h00};
			2'd2:    r = {cur[23:8], v};
			default: r = cur;
		endcase
		return r;
	endfunction

	assign b       = word.ie_byte;
	assign pos     = state.byte_position;
	assign run     = !state.parse_stopped && (state.parse_phase != PH_IDLE)
		&& (state.element_kind != KIND_NONE);
	assign sub_p   = pos[1:0];
	assign sub_l   = pos[1:0] - 2'd2;
	assign oui     = (state.element_kind == KIND_RSN) ? OUI_RSN : OUI_WPA;
	assign oui_hit = (state.suite_bytes == oui);
	assign cnt_new = {b, state.suite_count[7:0]};
	assign need    = {7'd0, pos} + 19'd1 + {1'b0, cnt_new, 2'b00};
	assign cnt_dec = state.suite_count - 16'd1;

	always_comb begin
		next  = state;
		len_w = {4'd0, b} + 12'd2;
		if (len_w > state.effective_length) len_w = state.effective_length;
		if (len_w > MAX_ELEMENT_BYTES) len_w = MAX_ELEMENT_BYTES;

		if (word.first_byte) begin
			next.effective_length = word.available_length;
			next.adhoc_flag       = word.adhoc_mode;
			next.acc_group        = word.prior_group;
			next.acc_pairwise     = word.prior_pairwise;
			next.acc_key_mgmt     = word.prior_key_mgmt;
			next.acc_protocols    = word.prior_protocols;
			next.suite_count      = '0;
			next.suite_bytes      = '0;
			next.parse_phase      = PH_LEN;
			next.parse_stopped    = 1'b0;
			next.byte_position    = 12'd1;
			if (b == ID_RSN) begin
				next.element_kind = KIND_RSN;
			end else if (b == ID_WPA) begin
				next.element_kind = KIND_WPA;
			end else begin
				next.element_kind  = KIND_NONE;
				next.parse_stopped = 1'b1;
			end
		end else begin
			if (run && state.parse_phase == PH_LEN) begin
				next.effective_length = len_w;
				if (state.element_kind == KIND_RSN) begin
					if (len_w < RSN_MIN_LEN) next.parse_stopped = 1'b1;
					else next.parse_phase = PH_VER;
				end else begin
					if (len_w < WPA_MIN_LEN) next.parse_stopped = 1'b1;
					else next.parse_phase = PH_HDR;
				end
			end else if (run && pos < state.effective_length) begin
				unique case (state.parse_phase)
					PH_HDR: begin
						if (b != WPA_HDR[sub_l]) next.parse_stopped = 1'b1;
						else if (sub_l == 2'd3) next.parse_phase = PH_VER;
					end
					PH_VER: begin
						if (pos[0]) begin
							next.acc_protocols = state.acc_protocols
								| ((state.element_kind == KIND_RSN) ? FLAG_RSN : FLAG_WPA);
							next.parse_phase = PH_GROUP;
						end
					end
					PH_GROUP: begin
						if (sub_p != 2'd3) begin
							next.suite_bytes = collect(sub_p, state.suite_bytes, b);
						end else begin
							if (oui_hit) next.acc_group = (b <= GROUP_MAX) ? b[2:0] : GROUP_UNDEF;
							next.parse_phase = PH_PCNT;
						end
					end
					PH_PCNT, PH_ACNT: begin
						if (!pos[0]) begin
							next.suite_count = {8'h00, b};
						end else begin
							next.suite_count = cnt_new;
							// whole list must fit inside the element
							if (need > {7'd0, state.effective_length}) begin
								next.parse_stopped = 1'b1;
							end else if (cnt_new == 16'd0) begin
								next.parse_phase = (state.parse_phase == PH_PCNT) ? PH_ACNT : PH_DONE;
							end else begin
								next.parse_phase = (state.parse_phase == PH_PCNT) ? PH_PLIST : PH_ALIST;
							end
						end
					end
					PH_PLIST: begin
						if (sub_l != 2'd3) begin
							next.suite_bytes = collect(sub_l, state.suite_bytes, b);
						end else begin
							if (oui_hit) begin
								if (b == PW_SEL_NONE) next.acc_pairwise = PW_NONE;
								else if (b == PW_SEL_TKIP) next.acc_pairwise = state.acc_pairwise | PW_TKIP;
								else if (b == PW_SEL_CCMP) next.acc_pairwise = state.acc_pairwise | PW_CCMP;
								else next.acc_pairwise = state.acc_pairwise | PW_UNKNOWN;
							end
							next.suite_count = cnt_dec;
							if (cnt_dec == 16'd0) next.parse_phase = PH_ACNT;
						end
					end
					PH_ALIST: begin
						if (sub_p != 2'd3) begin
							next.suite_bytes = collect(sub_p, state.suite_bytes, b);
						end else begin
							if (oui_hit) begin
								// a bare "none" gives way to the listed suites
								next.acc_key_mgmt = (state.acc_key_mgmt == KM_NONE) ? KM_UNDEF
									: state.acc_key_mgmt;
								if (b == AKM_SEL_NONE)
									next.acc_key_mgmt = next.acc_key_mgmt
										| (state.adhoc_flag ? KM_ADHOC_NONE : KM_NONE);
								else if (b == AKM_SEL_EAP)
									next.acc_key_mgmt = next.acc_key_mgmt | KM_EAP | KM_8021X;
								else if (b == AKM_SEL_PSK)
									next.acc_key_mgmt = next.acc_key_mgmt | KM_PSK;
							end
							next.suite_count = cnt_dec;
							if (cnt_dec == 16'd0) next.parse_phase = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			next.byte_position = (pos != POS_MAX) ? pos + 12'd1 : pos;
		end
	end

	assign res.group_cipher   = next.acc_group;
	assign res.pairwise_flags = next.acc_pairwise;
	assign res.key_mgmt_flags = next.acc_key_mgmt;
	assign res.protocol_flags = next.acc_protocols;

endmodule

// ===== rtl/core/wrip_out_fifo.sv =====
// small result buffer that drives the result channel
// depends on wrip_pkg and wrip_stream_if
module wrip_out_fifo import wrip_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wrip_out_t       push_data,
	wrip_stream_if.source   result,
	output wrip_fifo_stat_t stat
);

	wrip_out_t             entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	function automatic logic [FIFO_PTR_W-1:0] ptr_inc(logic [FIFO_PTR_W-1:0] p);
		return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
	endfunction

	assign pop            = result.valid && result.ready;
	assign result.valid   = (count_q != '0);
	assign result.payload = entries_q[rd_ptr_q];
	assign stat.count     = count_q;
	assign stat.full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
